### sv/ptft_pkg.sv
// Shared constants, widths and result type for the page table FIFO translator.
package ptft_pkg;

  localparam int PAGE_BYTES  = 256;
  localparam int PAGE_COUNT  = 8;
  localparam int FRAME_COUNT = 4;

  localparam int ADDR_W     = 16;
  localparam int PHYS_W     = 10;
  localparam int FRAME_OUT_W = 2;
  localparam int COUNT_W    = 32;

  localparam int OFFSET_W   = $clog2(PAGE_BYTES);
  localparam int PAGE_NUM_W = ADDR_W - OFFSET_W;
  localparam int PAGE_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int FRAME_W    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int FILL_W     = $clog2(FRAME_COUNT + 1);

  typedef struct packed {
    logic [PHYS_W-1:0]      physical_address;
    logic [FRAME_OUT_W-1:0] frame_used;
    logic                   was_hit;
    logic                   was_fault;
    logic                   address_invalid;
    logic [COUNT_W-1:0]     hits_so_far;
    logic [COUNT_W-1:0]     faults_so_far;
  } xlate_result_t;

endpackage

### sv/ptft_if.sv
// Valid/ready channel interfaces for translation requests and results.
interface ptft_req_if;
  logic                           valid;
  logic                           ready;
  logic [ptft_pkg::ADDR_W-1:0]    logical_address;

  modport source (output valid, output logical_address, input ready);
  modport sink   (input valid, input logical_address, output ready);
endinterface

interface ptft_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ptft_pkg::PHYS_W-1:0]       physical_address;
  logic [ptft_pkg::FRAME_OUT_W-1:0]  frame_used;
  logic                              was_hit;
  logic                              was_fault;
  logic                              address_invalid;
  logic [ptft_pkg::COUNT_W-1:0]      hits_so_far;
  logic [ptft_pkg::COUNT_W-1:0]      faults_so_far;

  modport source (output valid, output physical_address, output frame_used, output was_hit,
                  output was_fault, output address_invalid, output hits_so_far,
                  output faults_so_far, input ready);
  modport sink   (input valid, input physical_address, input frame_used, input was_hit,
                  input was_fault, input address_invalid, input hits_so_far,
                  input faults_so_far, output ready);
endinterface

### sv/ptft_xlate.sv
// Page table, frame owner table, FIFO replacement and counters; one lookup per cycle.
module ptft_xlate (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fire,
  input  logic [ptft_pkg::ADDR_W-1:0]     address,
  output ptft_pkg::xlate_result_t         result
);

  logic [ptft_pkg::PAGE_COUNT-1:0]   page_valid;
  logic [ptft_pkg::FRAME_W-1:0]      page_frame [ptft_pkg::PAGE_COUNT];
  logic [ptft_pkg::FRAME_COUNT-1:0]  owner_valid;
  logic [ptft_pkg::PAGE_W-1:0]       owner_page [ptft_pkg::FRAME_COUNT];
  logic [ptft_pkg::FILL_W-1:0]       filled;
  logic [ptft_pkg::FRAME_W-1:0]      evict_ptr;
  logic [ptft_pkg::COUNT_W-1:0]      hits;
  logic [ptft_pkg::COUNT_W-1:0]      faults;

  logic [ptft_pkg::PAGE_NUM_W-1:0]   page_num;
  logic [ptft_pkg::OFFSET_W-1:0]     offset;
  logic [ptft_pkg::PAGE_W-1:0]       pidx;
  logic                              invalid;
  logic                              hit;
  logic                              full;
  logic [ptft_pkg::FRAME_W-1:0]      frame;
  logic [ptft_pkg::FRAME_W-1:0]      evict_ptr_next;
  logic [ptft_pkg::COUNT_W-1:0]      hits_next;
  logic [ptft_pkg::COUNT_W-1:0]      faults_next;
  logic [ptft_pkg::PAGE_COUNT-1:0]   page_valid_next;

  assign page_num = address[ptft_pkg::ADDR_W-1:ptft_pkg::OFFSET_W];
  assign offset   = address[ptft_pkg::OFFSET_W-1:0];
  assign invalid  = {1'b0, page_num} >= (ptft_pkg::PAGE_NUM_W + 1)'(ptft_pkg::PAGE_COUNT);
  assign pidx     = ptft_pkg::PAGE_W'(page_num);
  assign hit      = page_valid[pidx];
  assign full     = filled == ptft_pkg::FILL_W'(ptft_pkg::FRAME_COUNT);

  always_comb begin
    if (hit) begin
      frame = page_frame[pidx];
    end else if (!full) begin
      frame = ptft_pkg::FRAME_W'(filled);
    end else begin
      frame = evict_ptr;
    end
  end

  assign evict_ptr_next = (evict_ptr == ptft_pkg::FRAME_W'(ptft_pkg::FRAME_COUNT - 1)) ?
                          '0 : evict_ptr + 1'b1;
  assign hits_next   = (hits == '1) ? hits : hits + 1'b1;
  assign faults_next = (faults == '1) ? faults : faults + 1'b1;

  // page valid bits after a miss: drop the previous owner of a recycled frame,
  // then mark the loaded page
  always_comb begin
    page_valid_next = page_valid;
    if (full && owner_valid[evict_ptr]) begin
      page_valid_next[owner_page[evict_ptr]] = 1'b0;
    end
    page_valid_next[pidx] = 1'b1;
  end

  always_comb begin
    result.hits_so_far   = (!invalid && hit) ? hits_next : hits;
    result.faults_so_far = (!invalid && !hit) ? faults_next : faults;
    if (invalid) begin
      result.physical_address = '0;
      result.frame_used       = '0;
      result.was_hit          = 1'b0;
      result.was_fault        = 1'b0;
      result.address_invalid  = 1'b1;
    end else begin
      result.physical_address = ptft_pkg::PHYS_W'({frame, offset});
      result.frame_used       = ptft_pkg::FRAME_OUT_W'(frame);
      result.was_hit          = hit;
      result.was_fault        = !hit;
      result.address_invalid  = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      page_valid  <= '0;
      owner_valid <= '0;
      filled      <= '0;
      evict_ptr   <= '0;
      hits        <= '0;
      faults      <= '0;
    end else if (fire && !invalid) begin
      if (hit) begin
        hits <= hits_next;
      end else begin
        faults <= faults_next;
        if (!full) begin
          filled <= filled + 1'b1;
        end else begin
          evict_ptr <= evict_ptr_next;
        end
        owner_valid[frame] <= 1'b1;
        page_valid         <= page_valid_next;
      end
    end
  end

  // payload tables, qualified by the valid bits above
  always_ff @(posedge clk) begin
    if (fire && !invalid && !hit) begin
      owner_page[frame] <= pidx;
      page_frame[pidx]  <= frame;
    end
  end

endmodule

### sv/page_table_fifo_translator_core.sv
// Top level: input register, translation logic and result register.
//
//   channel | dir | payload                                          | accepted when
//   --------+-----+--------------------------------------------------+----------------------
//   req     | in  | logical_address[15:0]                            | req.valid & req.ready
//   rsp     | out | physical_address, frame_used, was_hit, was_fault,| rsp.valid & rsp.ready
//           |     | address_invalid, hits_so_far, faults_so_far      |
//
// One item per cycle sustained while rsp.ready stays high. An accepted address
// sits in the input register; the page/frame table lookup and update then run
// on it and land in the result register together with the state change.
// Synchronous reset leaves every page unloaded, every frame free and both
// counters at zero. A stalled result stays put, as does a full input register;
// req.ready drops only when the input register is full and cannot move forward.
module page_table_fifo_translator_core (
  input logic       clk,
  input logic       rst,
  ptft_req_if.sink  req,
  ptft_rsp_if.source rsp
);

  // input register
  logic                          in_valid;
  logic [ptft_pkg::ADDR_W-1:0]   in_address;

  // result register
  logic                          out_valid;
  ptft_pkg::xlate_result_t       out_result;

  ptft_pkg::xlate_result_t       result;
  logic                          advance;   // input register moves into result register

  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_address <= req.logical_address;
    end
  end

  // table state commits on the same edge the result is captured
  ptft_xlate u_xlate (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .address (in_address),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.physical_address = out_result.physical_address;
  assign rsp.frame_used       = out_result.frame_used;
  assign rsp.was_hit          = out_result.was_hit;
  assign rsp.was_fault        = out_result.was_fault;
  assign rsp.address_invalid  = out_result.address_invalid;
  assign rsp.hits_so_far      = out_result.hits_so_far;
  assign rsp.faults_so_far    = out_result.faults_so_far;

endmodule

### sv/ptft_checker.sv
// Port-level checks for the translator result channel, bound to the top level.
module ptft_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic [ptft_pkg::PHYS_W-1:0]         physical_address,
  input logic [ptft_pkg::FRAME_OUT_W-1:0]    frame_used,
  input logic                                was_hit,
  input logic                                was_fault,
  input logic                                address_invalid,
  input logic [ptft_pkg::COUNT_W-1:0]        hits_so_far,
  input logic [ptft_pkg::COUNT_W-1:0]        faults_so_far
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(hits_so_far) && $stable(faults_so_far)
                                && $stable(physical_address))
    else $error("result changed while stalled");

  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $onehot({was_hit, was_fault, address_invalid}))
    else $error("hit, fault and invalid flags not exclusive");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && address_invalid |-> physical_address == '0 && frame_used == '0)
    else $error("invalid address produced a translation");

endmodule

bind page_table_fifo_translator_core ptft_checker u_ptft_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .physical_address (rsp.physical_address),
  .frame_used       (rsp.frame_used),
  .was_hit          (rsp.was_hit),
  .was_fault        (rsp.was_fault),
  .address_invalid  (rsp.address_invalid),
  .hits_so_far      (rsp.hits_so_far),
  .faults_so_far    (rsp.faults_so_far)
);
